// ===== rtl/uv_sphere_vertex_generator_assert.svh =====
// Assertion macros for the UV sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define UVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/uvs_pkg.sv =====
// Package: constants, tables and helpers of the UV sphere vertex generator
`default_nettype none
package uvs_pkg;

  localparam int MAX_DIVISIONS = 1024;
  localparam int ANGLE_BITS    = 16;

  localparam int IDX_W  = 11;
  localparam int RAD_W  = 16;
  localparam int POS_W  = 17;
  localparam int UNIT_W = 16;

  // divider: dividend holds index << ANGLE_BITS plus a rounding term
  localparam int QUO_W = ANGLE_BITS + 1;
  localparam int DVD_W = IDX_W + ANGLE_BITS + 1;
  localparam int DSR_W = IDX_W + 1;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int XY_W = 34;
  localparam int Z_W  = 33;
  localparam int FRAC_W = ANGLE_BITS - 2;
  localparam int MUL_W  = FRAC_W + 34;
  localparam logic [33:0] TWO_PI_Q30 = 34'd6746518852;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  localparam int SIDE_LEN = 1 + QUO_W + CORDIC_LAT;

  typedef enum logic [1:0] {
    REG_RADIUS       = 2'd0,
    REG_ROW_COUNT    = 2'd1,
    REG_COLUMN_COUNT = 2'd2
  } cfg_reg_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int step);
    logic signed [Z_W-1:0] v;
    case (step)
      0:  v = Z_W'(843314856);
      1:  v = Z_W'(497837829);
      2:  v = Z_W'(263043836);
      3:  v = Z_W'(133525158);
      4:  v = Z_W'(67021686);
      5:  v = Z_W'(33543515);
      6:  v = Z_W'(16775850);
      7:  v = Z_W'(8388437);
      8:  v = Z_W'(4194282);
      9:  v = Z_W'(2097149);
      10: v = Z_W'(1048575);
      11: v = Z_W'(524287);
      12: v = Z_W'(262143);
      13: v = Z_W'(131071);
      14: v = Z_W'(65535);
      15: v = Z_W'(32767);
      default: v = '0;
    endcase
    return v;
  endfunction

  // radius (Q8.8) times a Q1.14 unit term, rounded and clamped to Q8.8
  function automatic logic [POS_W-1:0] scale_q14(input logic [RAD_W-1:0] rad,
                                                 input logic signed [UNIT_W-1:0] u);
    logic signed [RAD_W:0]        rs;
    logic signed [RAD_W+UNIT_W:0] p;
    logic signed [RAD_W+UNIT_W:0] r;
    logic signed [RAD_W+UNIT_W:0] lim;
    rs  = $signed({1'b0, rad});
    p   = rs * u;
    r   = (p + (RAD_W+UNIT_W+1)'(8192)) >>> 14;
    lim = (RAD_W+UNIT_W+1)'(65535);
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/uvs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module uvs_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [uvs_pkg::DVD_W-1:0]   dvd,
  input  wire logic [uvs_pkg::DSR_W-1:0]   dsr,
  output logic      [uvs_pkg::QUO_W-1:0]   quo
);
  localparam int QW = uvs_pkg::QUO_W;
  localparam int DW = uvs_pkg::DVD_W;
  localparam int SW = uvs_pkg::DSR_W;

  logic [DW-1:0] rem  [1:QW];
  logic [SW-1:0] dsrp [1:QW];
  logic [QW-1:0] quop [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_cur;
    logic [SW-1:0] dsr_cur;
    logic [QW-1:0] quo_cur;
    logic [DW-1:0] shifted;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_cur = dvd;
      assign dsr_cur = dsr;
      assign quo_cur = '0;
    end else begin : g_rest
      assign rem_cur = rem[i];
      assign dsr_cur = dsrp[i];
      assign quo_cur = quop[i];
    end
    assign shifted = DW'(dsr_cur) << (QW - 1 - i);
    assign ge      = rem_cur >= shifted;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? rem_cur - shifted : rem_cur;
        dsrp[i+1] <= dsr_cur;
        quop[i+1] <= {quo_cur[QW-2:0], ge};
      end
    end
  end

  assign quo = quop[QW];
endmodule
`default_nettype wire

// ===== rtl/uvs_cordic.sv =====
// Pipelined sine/cosine: quadrant fold, 16 CORDIC stages, round to Q1.14
`default_nettype none
module uvs_cordic (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic [uvs_pkg::ANGLE_BITS-1:0]        angle,
  output logic signed [uvs_pkg::UNIT_W-1:0]          cos_q14,
  output logic signed [uvs_pkg::UNIT_W-1:0]          sin_q14
);
  localparam int N   = uvs_pkg::CORDIC_STEPS;
  localparam int XW  = uvs_pkg::XY_W;
  localparam int ZW  = uvs_pkg::Z_W;
  localparam int FW  = uvs_pkg::FRAC_W;
  localparam int MW  = uvs_pkg::MUL_W;
  localparam int AB  = uvs_pkg::ANGLE_BITS;
  localparam int UNIT_W_L = uvs_pkg::UNIT_W - 1;

  logic [MW-1:0]          prod;
  logic [MW-1:0]          prod_rnd;
  logic signed [ZW-1:0]   z0;
  logic [1:0]             q0;

  assign prod     = MW'(angle[FW-1:0]) * MW'(uvs_pkg::TWO_PI_Q30);
  assign prod_rnd = prod + (MW'(1) << (AB - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= ZW'(prod_rnd >> AB);
      q0 <= angle[AB-1:AB-2];
    end
  end

  logic signed [XW-1:0] xs [1:N];
  logic signed [XW-1:0] ys [1:N];
  logic signed [ZW-1:0] zs [1:N];
  logic [1:0]           qs [1:N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [XW-1:0] x_cur, y_cur, dx, dy;
    logic signed [ZW-1:0] z_cur;
    logic [1:0]           q_cur;
    if (i == 0) begin : g_first
      assign x_cur = uvs_pkg::CORDIC_GAIN;
      assign y_cur = '0;
      assign z_cur = z0;
      assign q_cur = q0;
    end else begin : g_rest
      assign x_cur = xs[i];
      assign y_cur = ys[i];
      assign z_cur = zs[i];
      assign q_cur = qs[i];
    end
    assign dx = y_cur >>> i;
    assign dy = x_cur >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_cur[ZW-1]) begin
          xs[i+1] <= x_cur - dx;
          ys[i+1] <= y_cur + dy;
          zs[i+1] <= z_cur - uvs_pkg::atan_q30(i);
        end else begin
          xs[i+1] <= x_cur + dx;
          ys[i+1] <= y_cur - dy;
          zs[i+1] <= z_cur + uvs_pkg::atan_q30(i);
        end
        qs[i+1] <= q_cur;
      end
    end
  end

  logic signed [XW-1:0]     xr, yr, lim;
  logic signed [UNIT_W_L:0] fc_w, fs_w;
  logic signed [uvs_pkg::UNIT_W-1:0] fc, fs, c_next, s_next;

  assign lim = XW'(16384);
  assign xr  = (xs[N] + XW'(32768)) >>> 16;
  assign yr  = (ys[N] + XW'(32768)) >>> 16;

  always_comb begin
    fc_w = (xr > lim) ? lim[UNIT_W_L:0] : ((xr < -lim) ? -lim[UNIT_W_L:0] : xr[UNIT_W_L:0]);
    fs_w = (yr > lim) ? lim[UNIT_W_L:0] : ((yr < -lim) ? -lim[UNIT_W_L:0] : yr[UNIT_W_L:0]);
    fc   = fc_w;
    fs   = fs_w;
    case (qs[N])
      2'd0:    begin c_next = fc;  s_next = fs;  end
      2'd1:    begin c_next = -fs; s_next = fc;  end
      2'd2:    begin c_next = -fc; s_next = -fs; end
      default: begin c_next = fs;  s_next = -fc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q14 <= c_next;
      sin_q14 <= s_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator: a 38-stage pipeline from grid index to Q8.8 vertex
// Usage:
//   Input channel in_valid/in_stall carries row and column of one grid point.
//   Output channel out_valid/out_stall carries pos_x, pos_y, pos_z and
//   index_error; a point outside the grid gives index_error = 1 and zeros.
//   Registers radius, row_count and column_count are written on cfg_write
//   at cfg_index; write them only while no request is in flight.
// Throughput: one request per cycle, back to back, while the output is not stalled.
// Stages: one input stage,
//   17 divider stages (one quotient bit each), 18 CORDIC stages (angle
//   scale, 16 rotations, rounding), a product stage and the output stage.
// Stall: while out_valid is high and out_stall is set, every stage holds
//   and in_stall is raised; bubbles are not squeezed out.
// Reset: rst clears all valid bits and loads radius 1.0 (256), 16 rows
//   and 16 columns.
`default_nettype none
module uv_sphere_vertex_generator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [uvs_pkg::RAD_W-1:0]          cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [uvs_pkg::IDX_W-1:0]          row,
  input  wire logic [uvs_pkg::IDX_W-1:0]          column,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [uvs_pkg::POS_W-1:0]        pos_x,
  output logic signed [uvs_pkg::POS_W-1:0]        pos_y,
  output logic signed [uvs_pkg::POS_W-1:0]        pos_z,
  output logic                                    index_error
);
  localparam int IW = uvs_pkg::IDX_W;
  localparam int AB = uvs_pkg::ANGLE_BITS;
  localparam int DW = uvs_pkg::DVD_W;
  localparam int SW = uvs_pkg::DSR_W;
  localparam int QW = uvs_pkg::QUO_W;
  localparam int UW = uvs_pkg::UNIT_W;
  localparam int SL = uvs_pkg::SIDE_LEN;
  localparam logic [IW-1:0] MAX_DIV = IW'(uvs_pkg::MAX_DIVISIONS);

  logic [uvs_pkg::RAD_W-1:0] radius;
  logic [IW-1:0]             row_count;
  logic [IW-1:0]             column_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 16'd256;
      row_count    <= IW'(16);
      column_count <= IW'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        uvs_pkg::REG_RADIUS:       radius       <= cfg_data;
        uvs_pkg::REG_ROW_COUNT:    row_count    <= cfg_data[IW-1:0];
        uvs_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input stage
  logic [IW-1:0] n, m;
  logic          err_in;
  assign n = (row_count > MAX_DIV) ? MAX_DIV : row_count;
  assign m = (column_count > MAX_DIV) ? MAX_DIV : column_count;
  assign err_in = (n == '0) || (m == '0) || (row > n) || (column > m);

  logic [DW-1:0] dvd_phi, dvd_theta;
  logic [SW-1:0] dsr_phi, dsr_theta;
  logic          side_v [0:SL-1];
  logic          side_e [0:SL-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_phi   <= (DW'(row) << AB) + DW'(n);
      dsr_phi   <= {n, 1'b0};
      dvd_theta <= (DW'(column) << AB) + DW'(m >> 1);
      dsr_theta <= {1'b0, m};
    end
  end

  // valid and error flags run alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SL; k++) side_v[k] <= 1'b0;
    end else if (adv) begin
      side_v[0] <= in_valid;
      for (int k = 1; k < SL; k++) side_v[k] <= side_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_e[0] <= err_in;
      for (int k = 1; k < SL; k++) side_e[k] <= side_e[k-1];
    end
  end

  logic [QW-1:0] q_phi, q_theta;

  uvs_div u_div_phi (
    .clk (clk), .en (adv), .dvd (dvd_phi), .dsr (dsr_phi), .quo (q_phi)
  );
  uvs_div u_div_theta (
    .clk (clk), .en (adv), .dvd (dvd_theta), .dsr (dsr_theta), .quo (q_theta)
  );

  logic signed [UW-1:0] cp, sp, ct, st;

  uvs_cordic u_cordic_phi (
    .clk (clk), .en (adv), .angle (q_phi[AB-1:0]), .cos_q14 (cp), .sin_q14 (sp)
  );
  uvs_cordic u_cordic_theta (
    .clk (clk), .en (adv), .angle (q_theta[AB-1:0]), .cos_q14 (ct), .sin_q14 (st)
  );

  // product stage
  logic signed [2*UW-1:0] px, pz;
  logic signed [UW-1:0]   p_ux, p_uz, p_cp;
  logic                   p_valid, p_err;

  assign px = ct * sp;
  assign pz = st * sp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= side_v[SL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_err <= side_e[SL-1];
      p_cp  <= cp;
      p_ux  <= UW'((px + (2*UW)'(8192)) >>> 14);
      p_uz  <= UW'((pz + (2*UW)'(8192)) >>> 14);
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      index_error <= p_err;
      pos_x <= p_err ? '0 : uvs_pkg::scale_q14(radius, p_ux);
      pos_y <= p_err ? '0 : uvs_pkg::scale_q14(radius, p_cp);
      pos_z <= p_err ? '0 : uvs_pkg::scale_q14(radius, p_uz);
    end
  end

`include "uv_sphere_vertex_generator_assert.svh"

  `UVS_ASSERT_NOW(a_err_zero, out_valid && index_error, (pos_x == '0) && (pos_y == '0) && (pos_z == '0), "out-of-grid point with nonzero coordinates")
  `UVS_ASSERT_NOW(a_y_bound, out_valid && !index_error, (pos_y <= $signed({1'b0, radius})) && (pos_y >= -$signed({1'b0, radius})), "pos_y exceeds radius")
  `UVS_ASSERT_NOW(a_x_bound, out_valid && !index_error, (pos_x <= $signed({1'b0, radius})) && (pos_x >= -$signed({1'b0, radius})), "pos_x exceeds radius")
  `UVS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid, "result dropped under stall")

endmodule
`default_nettype wire
